// ===== sv/ptts_pkg.sv =====
// ============================================================================
// Periodic task tick scheduler package
// Shared sizes, operation and result codes, control structs and helper
// functions for the scheduler's controller and datapath.
// ============================================================================
package ptts_pkg;

    // Table size and countdown width.
    localparam int SLOTS       = 8;
    localparam int TICK_WIDTH  = 16;
    localparam int SLOT_IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Item field widths.
    localparam int OP_W        = 2;
    localparam int SLOT_W      = 3;
    localparam int PERIOD_W    = 16;
    localparam int EVENT_W     = 2;
    localparam int IN_TDATA_W  = ((SLOT_W + PERIOD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SLOT_W + 7) / 8) * 8;

    // Largest countdown value.
    localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF >> (32 - TICK_WIDTH);

    // Operation codes of an input item.
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_ISSUE  = 2'd1,
        OP_TERM   = 2'd2,
        OP_UPDATE = 2'd3
    } op_t;

    // Result codes of an output item.
    typedef enum logic [EVENT_W-1:0] {
        EV_FIRED  = 2'd0,
        EV_ISSUED = 2'd1,
        EV_FULL   = 2'd2
    } event_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRE,
        ST_ISSUE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic do_tick;
        logic do_issue;
        logic do_term;
        logic do_update;
        logic emit_fire;
        logic emit_issue;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fire_any;
        logic fire_single;
        logic out_free;
    } status_t;

    // Converts a period in tenths of a millisecond to ticks: at a 10 kHz
    // tick the two are equal. Zero becomes one, and the result saturates.
    function automatic logic [TICK_WIDTH-1:0] to_ticks(input logic [PERIOD_W-1:0] period);
        logic [31:0] wide;
        wide = 32'(period);
        if (wide == 32'd0)
        begin
            wide = 32'd1;
        end
        if (wide > TICK_MAX)
        begin
            wide = TICK_MAX;
        end
        return TICK_WIDTH'(wide);
    endfunction

    // Index of the lowest set bit of a slot mask.
    function automatic logic [SLOT_IDX_W-1:0] lowest_set(input logic [SLOTS-1:0] mask);
        logic [SLOT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                idx = SLOT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== sv/ptts_ctrl.sv =====
// ============================================================================
// Scheduler controller
// State machine that accepts items, issues commands to the datapath and
// paces the delivery of results into the output register.
// ============================================================================
module ptts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         operation,
    input  ptts_pkg::status_t  status,
    output ptts_pkg::cmd_t     cmd
);
    import ptts_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    op_t    op;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(operation);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_TICK:
                        begin
                            cmd.do_tick = 1'b1;
                            if (status.fire_any)
                            begin
                                state_next = ST_FIRE;
                            end
                        end
                        OP_ISSUE:
                        begin
                            cmd.do_issue = 1'b1;
                            state_next   = ST_ISSUE;
                        end
                        OP_TERM:
                        begin
                            cmd.do_term = 1'b1;
                        end
                        OP_UPDATE:
                        begin
                            cmd.do_update = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FIRE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_fire = 1'b1;
                    if (status.fire_single)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_issue = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/ptts_datapath.sv =====
// ============================================================================
// Scheduler datapath
// Slot table with active flags, countdowns and reload values, the mask of
// slots due on the current tick, the pending issue result and the output
// register.
// ============================================================================
module ptts_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ptts_pkg::cmd_t                  cmd,
    output ptts_pkg::status_t               status,
    input  logic [ptts_pkg::SLOT_W-1:0]     slot,
    input  logic [ptts_pkg::PERIOD_W-1:0]   period,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ptts_pkg::EVENT_W-1:0]    event_res,
    output logic [ptts_pkg::SLOT_W-1:0]     slot_out,
    output logic                            last
);
    import ptts_pkg::*;

    logic [SLOTS-1:0]      active_reg;
    logic [TICK_WIDTH-1:0] countdown_reg [SLOTS];
    logic [TICK_WIDTH-1:0] reload_reg [SLOTS];
    logic [SLOTS-1:0]      fire_reg;
    logic [SLOTS-1:0]      fire_next;
    logic [SLOTS-1:0]      due;
    event_t                pend_event_reg;
    logic [SLOT_W-1:0]     pend_slot_reg;
    logic                  out_valid_reg;
    event_t                out_event_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic                  out_last_reg;
    logic [TICK_WIDTH-1:0] ticks;
    logic                  slot_ok;
    logic [SLOT_IDX_W-1:0] slot_idx;
    logic                  free_any;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [SLOT_IDX_W-1:0] fire_idx;
    logic                  out_load;

    assign ticks    = to_ticks(period);
    assign slot_ok  = (32'(slot) < 32'(SLOTS));
    assign slot_idx = SLOT_IDX_W'(slot);
    assign free_any = ~&active_reg;
    assign free_idx = lowest_set(~active_reg);
    assign fire_idx = lowest_set(fire_reg);
    assign out_load = cmd.emit_fire || cmd.emit_issue;

    // Slots whose countdown reaches zero on this tick.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            due[i] = active_reg[i] && (countdown_reg[i] == TICK_WIDTH'(1));
        end
    end

    // The due mask is loaded on a tick and loses its lowest bit per fired item.
    always_comb
    begin
        fire_next = fire_reg;
        if (cmd.do_tick)
        begin
            fire_next = due;
        end
        else if (cmd.emit_fire)
        begin
            fire_next = fire_reg & (fire_reg - SLOTS'(1));
        end
    end

    assign status.fire_any    = |due;
    assign status.fire_single = ((fire_reg & (fire_reg - SLOTS'(1))) == '0);
    assign status.out_free    = !out_valid_reg || m_tready;

    // Active flags and the mask of slots still to fire.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            fire_reg   <= '0;
        end
        else
        begin
            fire_reg <= fire_next;
            if (cmd.do_issue && free_any)
            begin
                active_reg[free_idx] <= 1'b1;
            end
            else if (cmd.do_term && slot_ok)
            begin
                active_reg[slot_idx] <= 1'b0;
            end
        end
    end

    // Countdown and reload values.
    always_ff @(posedge clk)
    begin
        if (cmd.do_tick)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (active_reg[i])
                begin
                    if (due[i])
                    begin
                        countdown_reg[i] <= reload_reg[i];
                    end
                    else
                    begin
                        countdown_reg[i] <= countdown_reg[i] - TICK_WIDTH'(1);
                    end
                end
            end
        end
        else if (cmd.do_issue && free_any)
        begin
            countdown_reg[free_idx] <= ticks;
            reload_reg[free_idx]    <= ticks;
        end
        else if (cmd.do_update && slot_ok && active_reg[slot_idx])
        begin
            reload_reg[slot_idx] <= ticks;
        end
    end

    // Result of an issue, held until the output register takes it.
    always_ff @(posedge clk)
    begin
        if (cmd.do_issue)
        begin
            if (free_any)
            begin
                pend_event_reg <= EV_ISSUED;
                pend_slot_reg  <= SLOT_W'(free_idx);
            end
            else
            begin
                pend_event_reg <= EV_FULL;
                pend_slot_reg  <= '0;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_fire)
        begin
            out_event_reg <= EV_FIRED;
            out_slot_reg  <= SLOT_W'(fire_idx);
            out_last_reg  <= status.fire_single;
        end
        else if (cmd.emit_issue)
        begin
            out_event_reg <= pend_event_reg;
            out_slot_reg  <= pend_slot_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign event_res = out_event_reg;
    assign slot_out  = out_slot_reg;
    assign last      = out_last_reg;

endmodule

// ===== sv/periodic_task_tick_scheduler.sv =====
// ============================================================================
// Periodic task tick scheduler
// Table of periodic task slots driven by a 10 kHz tick, with issue,
// terminate and update commands and fired events in ascending slot order.
// ============================================================================
// A tick item is accepted; if slots fire, the controller stays in the fire
// state and emits one result for each of them. An issue item passes through
// the issue state to emit its result; terminate and update items emit none.
// The single output register sets this pace: it takes one result per cycle,
// and a stall on m_tready holds the controller in place. A new item is taken
// once the previous item's results have all entered the output register, so
// the next item may be accepted while the last result still waits there.
module periodic_task_tick_scheduler (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ptts_pkg::IN_TDATA_W-1:0]       s_tdata,   // slot[2:0], period[18:3]
    input  logic [ptts_pkg::OP_W-1:0]             s_tuser,   // operation[1:0]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ptts_pkg::OUT_TDATA_W-1:0]      m_tdata,   // slot_out[2:0]
    output logic [ptts_pkg::EVENT_W-1:0]          m_tuser,   // event_res[1:0]
    output logic                                  m_tlast
);
    import ptts_pkg::*;

    cmd_t                cmd;
    status_t             status;
    logic [SLOT_W-1:0]   slot_out;

    ptts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .operation (s_tuser),
        .status    (status),
        .cmd       (cmd)
    );

    ptts_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .slot      (s_tdata[SLOT_W-1:0]),
        .period    (s_tdata[SLOT_W+PERIOD_W-1:SLOT_W]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .event_res (m_tuser),
        .slot_out  (slot_out),
        .last      (m_tlast)
    );

    // Result slot in the low bits, zero fill above.
    assign m_tdata = OUT_TDATA_W'(slot_out);

endmodule
